// ----- rtl/pcs_pkg.sv -----
// Shared types and constants of the piecewise-constant sampler.
package pcs_pkg;

  typedef enum logic [1:0] {
    ST_SAMPLE_OK  = 2'd0,
    ST_LOAD_OK    = 2'd1,
    ST_NOT_READY  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_e;

  localparam int unsigned OffsetW = 10;
  localparam int unsigned FracW   = 16;
  localparam int unsigned PdfCW   = 26;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

endpackage

// ----- rtl/pcs_if.sv -----
// Item channels of the sampler: one input channel, one result channel.
interface pcs_in_if #(
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned U_BITS      = 16
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   last_weight;
  logic [U_BITS-1:0]      u;

  modport source (output valid, kind, weight, last_weight, u, input ready);
  modport sink   (input valid, kind, weight, last_weight, u, output ready);
endinterface

interface pcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  offset;
  logic [15:0] fraction;
  logic [15:0] position;
  logic [25:0] pdf_continuous;
  logic [15:0] pdf_discrete;

  modport source (output valid, status, offset, fraction, position, pdf_continuous,
                  pdf_discrete, input ready);
  modport sink   (input valid, status, offset, fraction, position, pdf_continuous,
                  pdf_discrete, output ready);
endinterface

// ----- rtl/piecewise_constant_sampler_unit.sv -----
// Top level of the piecewise-constant sampler: table load, search and divide sequencer.
//
// Usage: one input channel (in_i) carries load and sample items, one result
// channel (out_o) returns exactly one result item per input item.
// A load item writes a weight and its prefix sum into two RAMs while the
// table has room; its result is registered in S_LOAD, the state after the accepting edge.
// A sample item runs a binary search over the prefix RAM, each step an
// address, a registered read and a compare state, for at most
// ceil(log2(count)) steps, then reads the chosen entry and computes four
// quotients through one shared restoring divider, each loaded in S_NEXT and
// worked out in S_DIV by compare-subtract steps.
// A sample before a completed table answers right after the accepting edge.
// The block takes one item at a time: ready is high only while idle, so a new
// item is taken only after the receiver has taken the result in S_OUT.
// A result sits in the output register until the receiver takes it; a
// stalled receiver holds the block, nothing is lost.
// Reset clears entry count, total, ready flag and the sequencer; the RAMs
// are not cleared, and only entries of the current table are ever read.
module piecewise_constant_sampler_unit
  import pcs_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned U_BITS      = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pcs_in_if.sink   in_i,
  pcs_out_if.source out_o
);
  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TW   = WEIGHT_BITS + CW;         // total width
  localparam int unsigned PW   = TW + U_BITS;              // u*total width
  localparam int unsigned DW0  = WEIGHT_BITS + U_BITS + FracW;
  localparam int unsigned DW2  = TW + PdfCW;
  localparam int unsigned NW   = (DW0 > DW2) ? DW0 : DW2;  // divider width
  localparam int unsigned QW   = PdfCW + 1;                // quotient width
  localparam int unsigned CNTW = $clog2(PdfCW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SRCH_ADDR, S_SRCH_WAIT, S_SRCH_CMP,
    S_FIN_ADDR, S_FIN_WAIT, S_DIV, S_NEXT, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_FRAC, PH_POS, PH_PDFC, PH_PDFD
  } phase_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [TW-1:0]      total_q;
  logic               ready_q;
  logic               last_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [U_BITS-1:0]  u_q;
  logic [CW-1:0]      lo_q, hi_q, mid_q;
  logic [PW-1:0]      target_q;
  logic [WEIGHT_BITS-1:0] wk_q;
  logic [TW-1:0]      sk_q;
  phase_e             phase_q;
  logic [NW-1:0]      rem_q;
  logic [QW-1:0]      quo_q;
  logic [NW-1:0]      den_q;
  logic [CNTW-1:0]    cnt_q;
  logic [15:0]        frac_q;
  logic [1:0]         st_q;
  logic [9:0]         off_q;
  logic [15:0]        pos_q, pd_q;
  logic [25:0]        pc_q;
  logic               ovalid_q;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [WEIGHT_BITS-1:0] wrd;
  logic [TW-1:0]      prd;
  logic               uniform;
  logic [TW-1:0]      tot_eff;
  logic [TW-1:0]      s_mid;
  logic [TW-1:0]      new_total;
  logic               div_take;
  logic [QW-1:0]      quo_nx;

  assign uniform   = (total_q == '0);
  assign tot_eff   = uniform ? TW'(count_q) : total_q;
  assign new_total = total_q + TW'(w_q);
  assign we        = (state_q == S_LOAD) && (count_q < CW'(MAX_ENTRIES));
  assign waddr     = count_q[AW-1:0];
  // read prefix at mid-1 during search, k during finish
  assign raddr     = (state_q == S_SRCH_ADDR || state_q == S_SRCH_WAIT) ?
                     AW'(mid_q - CW'(1)) : lo_q[AW-1:0];
  assign s_mid     = uniform ? TW'(mid_q) : prd;
  assign div_take  = (rem_q >= den_q);
  assign quo_nx    = {quo_q[QW-2:0], div_take};

  pcs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_wram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(w_q), .raddr_i(lo_q[AW-1:0]),
    .rdata_o(wrd)
  );
  pcs_ram #(.WIDTH(TW), .DEPTH(MAX_ENTRIES)) u_pram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(new_total), .raddr_i(raddr),
    .rdata_o(prd)
  );

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = ovalid_q;
  assign out_o.status         = st_q;
  assign out_o.offset         = off_q;
  assign out_o.fraction       = frac_q;
  assign out_o.position       = pos_q;
  assign out_o.pdf_continuous = pc_q;
  assign out_o.pdf_discrete   = pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      ready_q  <= 1'b0;
      ovalid_q <= 1'b0;
      last_q   <= 1'b0;
      w_q      <= '0;
      u_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      mid_q    <= '0;
      target_q <= '0;
      wk_q     <= '0;
      sk_q     <= '0;
      phase_q  <= PH_FRAC;
      rem_q    <= '0;
      quo_q    <= '0;
      den_q    <= '0;
      cnt_q    <= '0;
      frac_q   <= '0;
      st_q     <= ST_SAMPLE_OK;
      off_q    <= '0;
      pos_q    <= '0;
      pd_q     <= '0;
      pc_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            w_q    <= in_i.weight;
            last_q <= in_i.last_weight;
            u_q    <= in_i.u;
            st_q <= ST_SAMPLE_OK; off_q <= '0; frac_q <= '0; pos_q <= '0;
            pc_q <= '0; pd_q <= '0;
            if (in_i.kind == KIND_LOAD) begin
              if (ready_q) begin
                count_q <= '0;
                total_q <= '0;
                ready_q <= 1'b0;
              end
              state_q <= S_LOAD;
            end else if (!ready_q || count_q == '0) begin
              st_q     <= ST_NOT_READY;
              ovalid_q <= 1'b1;
              state_q  <= S_OUT;
            end else begin
              lo_q    <= '0;
              hi_q    <= count_q - CW'(1);
              state_q <= S_SRCH_ADDR;
            end
          end
        end
        S_LOAD: begin
          if (we) begin
            total_q <= new_total;
            count_q <= count_q + CW'(1);
            st_q    <= ST_LOAD_OK;
          end else begin
            st_q <= ST_TABLE_FULL;
          end
          if (last_q) ready_q <= 1'b1;
          ovalid_q <= 1'b1;
          state_q  <= S_OUT;
        end
        S_SRCH_ADDR: begin
          target_q <= PW'(u_q) * PW'(tot_eff);
          if (lo_q < hi_q) begin
            mid_q   <= lo_q + ((hi_q - lo_q + CW'(1)) >> 1);
            state_q <= S_SRCH_WAIT;
          end else begin
            state_q <= S_FIN_ADDR;
          end
        end
        S_SRCH_WAIT: state_q <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          if ((PW'(s_mid) << U_BITS) <= target_q) lo_q <= mid_q;
          else hi_q <= mid_q - CW'(1);
          state_q <= S_SRCH_ADDR;
        end
        S_FIN_ADDR: state_q <= S_FIN_WAIT;
        S_FIN_WAIT: begin
          // prd holds S(k+1), so S(k) = S(k+1) - w_k
          wk_q <= uniform ? WEIGHT_BITS'(1) : wrd;
          sk_q <= uniform ? TW'(lo_q) : prd - TW'(wrd);
          off_q <= OffsetW'(lo_q);
          phase_q <= PH_FRAC;
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          // load the shared divider; the divisor starts one bit above the
          // quotient width so that the top bit flags saturation
          rem_q <= '0;
          quo_q <= '0;
          unique case (phase_q)
            PH_FRAC: begin
              rem_q <= NW'(target_q - (PW'(sk_q) << U_BITS)) << FracW;
              den_q <= NW'(wk_q) << (U_BITS + FracW);
              cnt_q <= CNTW'(FracW);
            end
            PH_POS: begin
              rem_q <= (NW'(lo_q) << FracW) + NW'(frac_q);
              den_q <= NW'(count_q) << FracW;
              cnt_q <= CNTW'(FracW);
            end
            PH_PDFC: begin
              rem_q <= (NW'(wk_q) * NW'(count_q)) << FracW;
              den_q <= NW'(tot_eff) << PdfCW;
              cnt_q <= CNTW'(PdfCW);
            end
            default: begin
              rem_q <= NW'(wk_q) << FracW;
              den_q <= NW'(tot_eff) << FracW;
              cnt_q <= CNTW'(FracW);
            end
          endcase
          state_q <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit a cycle: compare, subtract, shift the divisor down
          if (div_take) rem_q <= rem_q - den_q;
          den_q <= den_q >> 1;
          quo_q <= quo_nx;
          cnt_q <= cnt_q - CNTW'(1);
          if (cnt_q == '0) begin
            unique case (phase_q)
              PH_FRAC: frac_q <= quo_nx[FracW] ? '1 : quo_nx[FracW-1:0];
              PH_POS:  pos_q  <= quo_nx[FracW] ? '1 : quo_nx[FracW-1:0];
              PH_PDFC: pc_q   <= quo_nx[PdfCW] ? '1 : quo_nx[PdfCW-1:0];
              default: pd_q   <= quo_nx[FracW] ? '1 : quo_nx[FracW-1:0];
            endcase
            if (phase_q == PH_PDFD) begin
              ovalid_q <= 1'b1;
              state_q  <= S_OUT;
            end else begin
              phase_q <= phase_e'(phase_q + 2'd1);
              state_q <= S_NEXT;
            end
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            ovalid_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/pcs_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
module pcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- bench/tb_piecewise_constant_sampler_unit.sv -----
// Testbench of the piecewise-constant sampler: random load and sample items, self-checking.
module tb_piecewise_constant_sampler_unit;
  import pcs_pkg::*;

  localparam int unsigned MaxEntries = 1024;

  typedef struct packed {
    status_e     status;
    logic [9:0]  offset;
    logic [15:0] fraction;
    logic [15:0] position;
    logic [25:0] pdf_continuous;
    logic [15:0] pdf_discrete;
  } sample_res_t;

  class sampler_scoreboard;
    logic [15:0] weights [MaxEntries];
    logic [25:0] prefix [MaxEntries];
    int unsigned n_entries;
    logic [25:0] total_sum;
    bit          complete;
    sample_res_t pending [$];
    int unsigned n_errors;
    int unsigned n_checked;

    function new();
      n_entries = 0;
      total_sum = '0;
      complete  = 1'b0;
      n_errors  = 0;
      n_checked = 0;
    endfunction

    function logic [63:0] sum_below(int unsigned k, bit flat);
      if (flat) return 64'(k);
      if (k == 0) return 64'd0;
      return 64'(prefix[k-1]);
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_item(kind_e kind, logic [15:0] w, bit last, logic [15:0] u);
      sample_res_t r;
      bit          flat;
      logic [63:0] tot, target, wk, d, frac, pos, pc, pd;
      int unsigned lo, hi, mid;
      r = '0;
      if (kind == KIND_LOAD) begin
        if (complete) begin
          n_entries = 0;
          total_sum = '0;
          complete  = 1'b0;
        end
        if (n_entries >= MaxEntries) begin
          r.status = ST_TABLE_FULL;
        end else begin
          weights[n_entries] = w;
          total_sum = total_sum + 26'(w);
          prefix[n_entries] = total_sum;
          n_entries++;
          r.status = ST_LOAD_OK;
        end
        if (last) complete = 1'b1;
      end else if (!complete || n_entries == 0) begin
        r.status = ST_NOT_READY;
      end else begin
        flat   = (total_sum == 0);
        tot    = flat ? 64'(n_entries) : 64'(total_sum);
        target = 64'(u) * tot;
        lo = 0;
        hi = n_entries - 1;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if ((sum_below(mid, flat) << 16) <= target) lo = mid;
          else hi = mid - 1;
        end
        wk   = flat ? 64'd1 : 64'(weights[lo]);
        d    = target - (sum_below(lo, flat) << 16);
        frac = (wk != 0) ? d / wk : 64'd0;
        if (frac > 64'hFFFF) frac = 64'hFFFF;
        pos = ((64'(lo) << 16) + frac) / n_entries;
        if (pos > 64'hFFFF) pos = 64'hFFFF;
        pc = ((wk * n_entries) << 16) / tot;
        if (pc > 64'h3FF_FFFF) pc = 64'h3FF_FFFF;
        pd = (wk << 16) / tot;
        if (pd > 64'hFFFF) pd = 64'hFFFF;
        r.status         = ST_SAMPLE_OK;
        r.offset         = lo[9:0];
        r.fraction       = frac[15:0];
        r.position       = pos[15:0];
        r.pdf_continuous = pc[25:0];
        r.pdf_discrete   = pd[15:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(sample_res_t got);
      sample_res_t exp;
      n_checked++;
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        n_errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status); n_errors++;
      end
      if (got.offset !== exp.offset) begin
        $error("offset: expected %0d, got %0d", exp.offset, got.offset); n_errors++;
      end
      if (got.fraction !== exp.fraction) begin
        $error("fraction: expected %h, got %h", exp.fraction, got.fraction); n_errors++;
      end
      if (got.position !== exp.position) begin
        $error("position: expected %h, got %h", exp.position, got.position); n_errors++;
      end
      if (got.pdf_continuous !== exp.pdf_continuous) begin
        $error("pdf_continuous: expected %h, got %h", exp.pdf_continuous,
               got.pdf_continuous);
        n_errors++;
      end
      if (got.pdf_discrete !== exp.pdf_discrete) begin
        $error("pdf_discrete: expected %h, got %h", exp.pdf_discrete, got.pdf_discrete);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pcs_in_if  in_if ();
  pcs_out_if out_if ();

  piecewise_constant_sampler_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sampler_scoreboard sb;
  int unsigned n_loads;
  int unsigned n_samples;
  bit          no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("piecewise_constant_sampler_unit test failed");
    $finish;
  end

  // Offer one item after a random gap (none with no_gaps); return once it has been accepted.
  task automatic send_item(kind_e kind, logic [15:0] w, bit last, logic [15:0] u);
    int unsigned gap;
    gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.weight      <= w;
    in_if.last_weight <= last;
    in_if.u           <= u;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(kind, w, last, u);
    if (kind == KIND_LOAD) n_loads++;
    else n_samples++;
  endtask

  task automatic load_weight(logic [15:0] w, bit last);
    send_item(KIND_LOAD, w, last, 16'($urandom()));
  endtask

  task automatic sample(logic [15:0] u);
    send_item(KIND_SAMPLE, 16'($urandom()), 1'($urandom_range(0, 1)), u);
  endtask

  function automatic logic [15:0] draw_weight(int unsigned mode);
    case (mode)
      0: return 16'($urandom());
      1: return ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom());
      2: return 16'd0;
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [15:0] draw_u();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Load a table of random length and content, then query it.
  task automatic random_table();
    int unsigned len, mode, n_q;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    mode = $urandom_range(0, 3);
    for (int unsigned i = 0; i < len; i++) begin
      load_weight(draw_weight(mode), i == len - 1);
      // a query in the middle of a load finds no table
      if (i != len - 1 && $urandom_range(0, 15) == 0) sample(draw_u());
    end
    n_q = $urandom_range(2, 10);
    for (int unsigned i = 0; i < n_q; i++) sample(draw_u());
  endtask

  // Receiver: random stalls, one long hold-off to back up the block.
  initial begin
    int unsigned stall;
    int unsigned n_rx;
    sample_res_t got;
    n_rx = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (n_rx == 60) stall = 400;
      else if (no_gaps) stall = 0;
      else stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      got.status         = status_e'(out_if.status);
      got.offset         = out_if.offset;
      got.fraction       = out_if.fraction;
      got.position       = out_if.position;
      got.pdf_continuous = out_if.pdf_continuous;
      got.pdf_discrete   = out_if.pdf_discrete;
      sb.check_result(got);
      n_rx++;
    end
  end

  initial begin
    int unsigned wait_cycles;
    sb = new();
    n_loads   = 0;
    n_samples = 0;
    no_gaps   = 1'b0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_LOAD;
    in_if.weight      = '0;
    in_if.last_weight = 1'b0;
    in_if.u           = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no table yet
    sample(16'h1234);
    // single extreme weight
    load_weight(16'hFFFF, 1'b1);
    sample(16'h0000);
    sample(16'hFFFF);
    // all-zero weights: uniform
    load_weight(16'h0000, 1'b0);
    load_weight(16'h0000, 1'b0);
    load_weight(16'h0000, 1'b1);
    sample(16'h0000);
    sample(16'h5555);
    sample(16'hFFFF);
    // zero-weight segments are skipped; the first query comes before the table is complete
    load_weight(16'h0000, 1'b0);
    load_weight(16'h0005, 1'b0);
    sample(16'h8000);
    load_weight(16'h0000, 1'b0);
    load_weight(16'hFFFF, 1'b0);
    load_weight(16'h0000, 1'b1);
    sample(16'h0000);
    sample(16'h0001);
    sample(16'h8000);
    sample(16'hFFFF);

    for (int unsigned i = 0; i < 15; i++) random_table();

    // one long table sent back to back, for a deeper search
    no_gaps = 1'b1;
    for (int unsigned i = 0; i < 200; i++)
      load_weight(draw_weight(1), i == 199);
    no_gaps = 1'b0;
    for (int unsigned i = 0; i < 12; i++) sample(draw_u());

    for (int unsigned i = 0; i < 5; i++) random_table();

    in_if.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 200_000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    $display("covered %0d load items and %0d sample items, %0d results checked",
             n_loads, n_samples, sb.n_checked);
    $display("tables: directed, random lengths and weights, uniform, one long table");
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("piecewise_constant_sampler_unit test passed");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("piecewise_constant_sampler_unit test failed");
    end
    $finish;
  end

endmodule
